// File: rtl/spm_pkg.sv
// Shared types and constants for the spiral order matrix scan.
package spm_pkg;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // walker control from the top-level sequencer
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

endpackage

// File: rtl/spm_store.sv
// Element store: one write port, one registered read port.
module spm_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [spm_pkg::ELEM_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [spm_pkg::ELEM_W-1:0] rdata
);
  import spm_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spm_walker.sv
// Spiral address walker: bounds, position and direction, one cell per step.
module spm_walker #(
  parameter int unsigned DIM_W  = 3,
  parameter int unsigned DIM1_W = 4,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned CNT_W  = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  spm_pkg::walk_ctl_t ctl,
  input  logic [DIM1_W-1:0]  nrows,
  input  logic [DIM1_W-1:0]  ncols,
  input  logic [CNT_W-1:0]   total,
  output logic [ADDR_W-1:0]  rd_addr,
  output logic               last
);
  import spm_pkg::*;

  localparam int unsigned PROD_W = DIM_W + DIM1_W;

  dir_t             dir, dir_next;
  logic [DIM_W-1:0] row, row_next, col, col_next;
  logic [DIM_W-1:0] top, top_next, left, left_next;
  logic [DIM_W-1:0] bottom, bottom_next, right, right_next;
  logic [CNT_W-1:0] n;
  logic [DIM_W-1:0] row_sel, col_sel;
  logic [PROD_W-1:0] lin;

  always_comb begin
    dir_next    = dir;
    row_next    = row;
    col_next    = col;
    top_next    = top;
    left_next   = left;
    bottom_next = bottom;
    right_next  = right;
    case (dir)
      DIR_RIGHT: begin
        if (col == right) begin
          top_next = top + 1'b1;
          dir_next = DIR_DOWN;
          row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      DIR_DOWN: begin
        if (row == bottom) begin
          right_next = right - 1'b1;
          dir_next   = DIR_LEFT;
          col_next   = col - 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end
      DIR_LEFT: begin
        if (col == left) begin
          bottom_next = bottom - 1'b1;
          dir_next    = DIR_UP;
          row_next    = row - 1'b1;
        end else begin
          col_next = col - 1'b1;
        end
      end
      DIR_UP: begin
        if (row == top) begin
          left_next = left + 1'b1;
          dir_next  = DIR_RIGHT;
          col_next  = col + 1'b1;
        end else begin
          row_next = row - 1'b1;
        end
      end
      default: begin
        dir_next = DIR_RIGHT;
      end
    endcase
  end

  // read the next cell in the same cycle as a step so data keeps pace
  always_comb begin
    row_sel = ctl.step ? row_next : row;
    col_sel = ctl.step ? col_next : col;
    lin     = PROD_W'(row_sel) * PROD_W'(ncols) + PROD_W'(col_sel);
    rd_addr = lin[ADDR_W-1:0];
  end

  assign last = (n == total - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= DIR_RIGHT;
      n   <= '0;
    end else if (ctl.start) begin
      dir <= DIR_RIGHT;
      n   <= '0;
    end else if (ctl.step) begin
      dir <= dir_next;
      n   <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      row    <= '0;
      col    <= '0;
      top    <= '0;
      left   <= '0;
      bottom <= DIM_W'(nrows - 1'b1);
      right  <= DIM_W'(ncols - 1'b1);
    end else if (ctl.step) begin
      row    <= row_next;
      col    <= col_next;
      top    <= top_next;
      left   <= left_next;
      bottom <= bottom_next;
      right  <= right_next;
    end
  end

endmodule

// File: rtl/spiral_order_matrix_scan.sv
// Top level: load sequencer, walker and element store of the spiral scan.
// Load: one input beat per cycle; the beat that completes rows*cols elements
// starts the walk. The sequencer then passes through ST_PRIME, while the store
// reads the first cell, into ST_EMIT, where the first output beat is valid; then one
// output beat per cycle while m_tready is high; the address walker sets this.
// Reset (rst, synchronous) clears the load count, returns the sequencer to loading and returns rows/cols to 8.
module spiral_order_matrix_scan #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [spm_pkg::ELEM_W-1:0]    s_tdata,   // [31:0] element
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [spm_pkg::ELEM_W-1:0]    m_tdata,   // [31:0] element_out
  output logic                          m_tlast,   // is_last
  input  logic                          cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spm_pkg::CFG_W-1:0]     cfg_data
);
  import spm_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned DIM_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM1_W = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  state_t            state, state_next;
  logic [CFG_W-1:0]  rows, cols;
  logic [DIM1_W-1:0] nrows, ncols;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_count, load_count_next;
  logic              s_beat, m_beat, load_done;
  walk_ctl_t         ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= CFG_W'(8);
      cols <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows <= cfg_data;
        REG_COLS: cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range dimensions: zero reads as one, large clamps to MAX_DIM
  always_comb begin
    if (rows == '0)                  nrows = DIM1_W'(1);
    else if (rows > CFG_W'(MAX_DIM)) nrows = DIM1_W'(MAX_DIM);
    else                             nrows = DIM1_W'(rows);
    if (cols == '0)                  ncols = DIM1_W'(1);
    else if (cols > CFG_W'(MAX_DIM)) ncols = DIM1_W'(MAX_DIM);
    else                             ncols = DIM1_W'(cols);
    total = CNT_W'(nrows) * CNT_W'(ncols);
  end

  assign s_tready  = (state == ST_LOAD);
  assign m_tvalid  = (state == ST_EMIT);
  assign m_tlast   = last;
  assign s_beat    = s_tvalid && s_tready;
  assign m_beat    = m_tvalid && m_tready;
  assign load_done = ((load_count + 1'b1) >= total);

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    ctl.start       = 1'b0;
    ctl.step        = 1'b0;
    case (state)
      ST_LOAD: begin
        if (s_beat) begin
          if (load_done) begin
            load_count_next = '0;
            ctl.start       = 1'b1;
            state_next      = ST_PRIME;
          end else begin
            load_count_next = load_count + 1'b1;
          end
        end
      end
      ST_PRIME: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_beat) begin
          if (last) begin
            state_next = ST_LOAD;
          end else begin
            ctl.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
    end
  end

  spm_walker #(
    .DIM_W  (DIM_W),
    .DIM1_W (DIM1_W),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .nrows   (nrows),
    .ncols   (ncols),
    .total   (total),
    .rd_addr (rd_addr),
    .last    (last)
  );

  spm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (s_beat),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (m_tdata)
  );

endmodule

// File: rtl/spm_checker.sv
// Port-level checks for the spiral scan, bound to the top level.
module spm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [spm_pkg::ELEM_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import spm_pkg::*;

  // never loading and emitting at once
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("load and emit overlap");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // the last beat of a spiral hands control back to loading
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("no return to load after last beat");

  // emission starts only after a completing input beat, once ST_PRIME has passed
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("emission without a completing input beat");

endmodule

bind spiral_order_matrix_scan spm_checker u_spm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: tb/spiral_scan_checker.sv
`timescale 1ns / 100ps
// Spiral scan checker: tracks loads and config, predicts spiral-order beats, compares outputs.
module spiral_scan_checker #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [spm_pkg::ELEM_W-1:0]    s_tdata,   // [31:0] element
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [spm_pkg::ELEM_W-1:0]    m_tdata,   // [31:0] element_out
  input  logic                          m_tlast,   // is_last
  input  logic                          cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spm_pkg::CFG_W-1:0]     cfg_data,
  output int                            pending_beats,
  output int                            mismatches
);
  import spm_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last;
  } spiral_beat_t;

  logic [ELEM_W-1:0] matrix_mem [STORE_DEPTH];
  logic [6:0]        loaded;
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;
  spiral_beat_t      spiral_q [$];
  spiral_beat_t      want;
  int                err_count;
  int unsigned       nr;
  int unsigned       nc;

  function automatic int unsigned dim_in_use(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void queue_cell(int r, int c, int ncols, int total, inout int n);
    spiral_beat_t b;
    b.element = matrix_mem[(r * ncols + c) % STORE_DEPTH];
    b.last    = (n == total - 1);
    spiral_q.insert(spiral_q.size(), b);
    n++;
  endfunction

  // clockwise walk with shrinking bounds; the count guard stops odd centers and thin shapes
  function automatic void queue_spiral(int unsigned nrows, int unsigned ncols);
    int total;
    int n;
    int row_lo;
    int row_hi;
    int col_lo;
    int col_hi;
    int i;
    total  = nrows * ncols;
    n      = 0;
    row_lo = 0;
    col_lo = 0;
    row_hi = nrows - 1;
    col_hi = ncols - 1;
    while (n < total) begin
      for (i = col_lo; i <= col_hi && n < total; i++) queue_cell(row_lo, i, ncols, total, n);
      row_lo++;
      for (i = row_lo; i <= row_hi && n < total; i++) queue_cell(i, col_hi, ncols, total, n);
      col_hi--;
      for (i = col_hi; i >= col_lo && n < total; i--) queue_cell(row_hi, i, ncols, total, n);
      row_hi--;
      for (i = row_hi; i >= row_lo && n < total; i--) queue_cell(i, col_lo, ncols, total, n);
      col_lo++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      loaded   = '0;
      rows_reg = CFG_W'(8);
      cols_reg = CFG_W'(8);
      spiral_q.delete();
    end else begin
      // outputs first, so a beat can never match an expectation pushed at the same edge
      if (m_tvalid && m_tready) begin
        if (spiral_q.size() == 0) begin
          $error("unexpected output beat: element_out %0d, is_last %0b",
                 $signed(m_tdata), m_tlast);
          err_count++;
        end else begin
          want = spiral_q.pop_front();
          if (m_tdata !== want.element) begin
            $error("element_out: expected %0d, got %0d", $signed(want.element),
                   $signed(m_tdata));
            err_count++;
          end
          if (m_tlast !== want.last) begin
            $error("is_last: expected %0b, got %0b", want.last, m_tlast);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        matrix_mem[loaded % STORE_DEPTH] = s_tdata;
        loaded = loaded + 7'd1;
        nr = dim_in_use(rows_reg);
        nc = dim_in_use(cols_reg);
        if (loaded >= nr * nc) begin
          loaded = '0;
          queue_spiral(nr, nc);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS: rows_reg = cfg_data;
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending_beats <= spiral_q.size();
    mismatches    <= err_count;
  end

endmodule

// File: tb/spiral_order_matrix_scan_test.sv
`timescale 1ns / 100ps
// Top of the spiral scan testbench: clock, reset, stimulus, output stalls and verdict.
module spiral_order_matrix_scan_test;
  import spm_pkg::*;

  localparam int unsigned MAX_DIM       = 8;
  localparam int          ITEM_TARGET   = 220;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          CYCLE_LIMIT   = 400000;

  // indexes with no register behind them; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [ELEM_W-1:0]    s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [ELEM_W-1:0]    m_tdata;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int pending_beats;
  int mismatches;
  int items_sent    = 0;
  int tx_calm_left  = 0;
  int rx_calm_left  = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int cycle_count   = 0;

  always #5 clk = ~clk;

  spiral_order_matrix_scan #(.MAX_DIM(MAX_DIM)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  spiral_scan_checker #(.MAX_DIM(MAX_DIM)) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending_beats(pending_beats),
    .mismatches   (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned dim_in_use(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // mostly small shapes; full size, zero and oversized values now and then
  function automatic logic [CFG_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return CFG_W'($urandom_range(1, 4));
    if (roll < 15) return CFG_W'($urandom_range(5, 7));
    if (roll < 17) return CFG_W'(8);
    if (roll == 17) return '0;
    return CFG_W'($urandom_range(9, 15));
  endfunction

  task automatic send_element(input logic [ELEM_W-1:0] value);
    int gap;
    if (tx_calm_left > 0) begin
      gap = 0;
      tx_calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      tx_calm_left = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_element($urandom);
  endtask

  // sender pause: nothing offered until every predicted beat has come out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    wait_for_results();
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
  endtask

  // receiver: random stalls, calm stretches, and long hold-offs on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_calm_left > 0) begin
        stall = 0;
        rx_calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        rx_calm_left = $urandom_range(8, 30);
      end else begin
        stall = $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_requests == holds_done);
    end
  end

  initial begin
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] c;
    int               total;
    int               partial;
    int               phase;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape is 8x8, so these five stay in the store; shrinking to 1x2 then fires
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0001);
    set_dims(CFG_W'(1), CFG_W'(2));
    send_element(32'h5555_5555);

    // zero dims are used as one
    set_dims('0, '0);
    send_element(32'hAAAA_AAAA);

    // single row, single column
    set_dims(CFG_W'(1), CFG_W'(3));
    send_random(3);
    set_dims(CFG_W'(3), CFG_W'(1));
    send_random(3);

    // odd center; the spare indexes must not disturb the shape
    set_dims(CFG_W'(3), CFG_W'(3));
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    send_random(9);

    // growing the shape mid-load keeps what was loaded
    set_dims(CFG_W'(2), CFG_W'(1));
    send_random(1);
    set_dims(CFG_W'(2), CFG_W'(2));
    send_random(3);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        // hold the output just before a matrix completes while the sender keeps offering input
        set_dims(CFG_W'(3), CFG_W'(4));
        send_random(11);
        hold_requests++;
        send_random(25);
      end else if (phase == 1) begin
        set_dims(CFG_W'(15), CFG_W'(8));
        send_random(64);
      end else begin
        r = pick_dim();
        c = pick_dim();
        if ($urandom_range(0, 7) == 0) begin
          wait_for_results();
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        end
        set_dims(r, c);
        total = dim_in_use(r) * dim_in_use(c);
        if (total > 1 && $urandom_range(0, 5) == 0) begin
          // reshape in the middle of a load
          partial = $urandom_range(1, total - 1);
          send_random(partial);
          r = pick_dim();
          c = pick_dim();
          set_dims(r, c);
          total = dim_in_use(r) * dim_in_use(c);
          send_random((partial + 1 >= total) ? 1 : total - partial);
        end else begin
          send_random(total * $urandom_range(1, 3));
        end
      end
      phase++;
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/spm_pkg.sv
rtl/spm_store.sv
rtl/spm_walker.sv
rtl/spiral_order_matrix_scan.sv
rtl/spm_checker.sv
tb/spiral_scan_checker.sv
tb/spiral_order_matrix_scan_test.sv
